// ===== src/gre_pkg.sv =====
// Shared types, constants and helpers of the Golomb-Rice / Exp-Golomb encoder.
// No dependencies; used by the chunker, the top level, the checker and the testbench.
package gre_pkg;

    // Default clamp for the coding parameter k
    localparam int MAX_K_DEFAULT = 16;

    // Field and internal widths
    localparam int RES_W    = 64;   // residual and zigzag value
    localparam int CHUNK_W  = 32;   // bits per full chunk
    localparam int LEN_W    = 6;    // chunk_len field
    localparam int CODE_W   = 97;   // longest codeword: escape form
    localparam int UPPER_W  = 96;   // codeword bits above the final chunk
    localparam int POS_W    = 7;    // payload bit count, up to RES_W
    localparam int UNARY_W  = 6;    // unary count, up to ESC_UNARY
    localparam int CIDX_W   = 2;    // chunk index within one codeword
    localparam int CFG_IDX_W = 8;
    localparam int CFG_VAL_W = 32;

    localparam logic [CHUNK_W-1:0] ONES32    = 32'hFFFF_FFFF;
    localparam int                 MAX_UNARY = 31;
    localparam logic [UNARY_W-1:0] ESC_UNARY = 6'd32;
    localparam logic [POS_W-1:0]   ESC_POS   = 7'd64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RICE_K       = 8'd0,
        CFG_CODER_SELECT = 8'd1
    } cfg_index_t;

    // Coder modes
    localparam logic MODE_RICE = 1'b0;
    localparam logic MODE_EXPG = 1'b1;

    // Words on the channels
    typedef struct packed {
        logic signed [RES_W-1:0] residual;
    } res_word_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_bits;
        logic [LEN_W-1:0]   chunk_len;
        logic               escaped;
        logic               last;
    } chunk_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_word_t;

    // Finished codeword handed from the pipeline to the chunker
    typedef struct packed {
        logic [CODE_W-1:0] value;   // right-aligned codeword
        logic [LEN_W-1:0]  fin_len; // bits in the final chunk, 1..32
        logic [CIDX_W-1:0] nlast;   // index of the final chunk
        logic              esc;
    } code_t;

    // Position of the highest set bit of a 32-bit word (binary search)
    function automatic logic [4:0] floor_log2_32(input logic [31:0] v);
        logic [31:0] x;
        logic [4:0]  n;
        x = v;
        n = '0;
        if (x[31:16] != 16'd0) begin n[4] = 1'b1; x = x >> 16; end
        if (x[15:8]  != 8'd0)  begin n[3] = 1'b1; x = x >> 8;  end
        if (x[7:4]   != 4'd0)  begin n[2] = 1'b1; x = x >> 4;  end
        if (x[3:2]   != 2'd0)  begin n[1] = 1'b1; x = x >> 2;  end
        if (x[1]     != 1'b0)  begin n[0] = 1'b1; end
        return n;
    endfunction

endpackage

// ===== src/gre_stream_if.sv =====
// Valid/ready stream channel carrying one word of a chosen packed type.
// Word types come from gre_pkg.
interface gre_stream_if #(
    parameter type word_t = logic
) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/golomb_rice_exp_golomb_encoder.sv =====
// Top level of the Golomb-Rice / order-k Exp-Golomb residual encoder.
// Depends on gre_pkg, gre_stream_if and gre_chunker.
//
// Channel   Modport  Word                 Handshake
// res       sink     residual (64, s)     valid && ready
// chunk     source   chunk_bits/len/      valid && ready
//                    escaped/last
// cfg       sink     index (8), value(32) valid && ready, ready always high
//
// Six register stages (zigzag, add 2^k, shift and escape test, log2, mask,
// codeword assembly) feed the chunker, which registers each codeword. One
// residual enters per cycle while each codeword fits one chunk and
// chunk.ready stays high; a codeword of m chunks (up to 4, escape is 4)
// holds the chunker until all m are sent, and the stages stall behind it
// without loss. Reset clears the valid bits and rice_k and coder_select.
module golomb_rice_exp_golomb_encoder #(
    parameter int MAX_K = gre_pkg::MAX_K_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    gre_stream_if.sink   res,
    gre_stream_if.source chunk,
    gre_stream_if.sink   cfg
);

    localparam int KW = $clog2(MAX_K + 1);

    // Configuration registers
    logic [4:0] rice_k_reg;
    logic       coder_select_reg;
    logic [KW-1:0] k_eff;

    // Stage registers
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s6_ready;
    logic code_ready;

    logic [63:0]   s1_zz_reg;
    logic [KW-1:0] s1_k_reg;
    logic          s1_mode_reg;
    logic [63:0]   s1_zz_next;

    logic [63:0]   s2_zz_reg;
    logic [64:0]   s2_adj_reg;
    logic [KW-1:0] s2_k_reg;
    logic          s2_mode_reg;
    logic [64:0]   s2_adj_next;

    logic [63:0]   s3_zz_reg;
    logic [63:0]   s3_src_reg;
    logic [31:0]   s3_t_reg;
    logic [KW-1:0] s3_k_reg;
    logic          s3_mode_reg;
    logic          s3_esc_reg;
    logic [63:0]   s3_src_next;
    logic [63:0]   s3_sh;
    logic          s3_esc_next;

    logic [gre_pkg::UNARY_W-1:0] s4_u_reg;
    logic [gre_pkg::POS_W-1:0]   s4_pos_reg;
    logic [63:0]                 s4_low_reg;
    logic                        s4_esc_reg;
    logic [4:0]                  s4_pre;
    logic [gre_pkg::UNARY_W-1:0] s4_u_next;
    logic [gre_pkg::POS_W-1:0]   s4_pos_next;
    logic [gre_pkg::POS_W-1:0]   s4_k_wide;
    logic [63:0]                 s4_low_next;

    logic [gre_pkg::UNARY_W-1:0] s5_u_reg;
    logic [gre_pkg::POS_W-1:0]   s5_pos_reg;
    logic [63:0]                 s5_low_reg;
    logic [gre_pkg::POS_W-1:0]   s5_len_reg;
    logic                        s5_esc_reg;
    logic [63:0]                 s5_low_next;
    logic [gre_pkg::POS_W-1:0]   s5_len_next;

    gre_pkg::code_t              s6_code_reg;
    gre_pkg::code_t              s6_code_next;
    logic [31:0]                 s6_ones;
    logic [gre_pkg::POS_W-1:0]   s6_lm1;

    // Take configuration writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_k_reg       <= '0;
            coder_select_reg <= gre_pkg::MODE_RICE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                gre_pkg::CFG_RICE_K:       rice_k_reg       <= cfg.data.value[4:0];
                gre_pkg::CFG_CODER_SELECT: coder_select_reg <= cfg.data.value[0];
                default: ;
            endcase
        end
    end

    // Saturate k at MAX_K
    assign k_eff = (int'(rice_k_reg) > MAX_K) ? KW'(MAX_K) : rice_k_reg[KW-1:0];

    // Stall chain: a stage takes a word when it is empty or drains
    assign s6_ready  = !s6_valid_reg || code_ready;
    assign s5_ready  = !s5_valid_reg || s6_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign res.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= res.valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
            if (s6_ready) s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 1: zigzag map, snapshot k and mode
    assign s1_zz_next = {res.data.residual[62:0], 1'b0} ^ {64{res.data.residual[63]}};

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_zz_reg   <= s1_zz_next;
            s1_k_reg    <= k_eff;
            s1_mode_reg <= coder_select_reg;
        end
    end

    // Stage 2: add 2^k, keep the carry for the overflow test
    assign s2_adj_next = {1'b0, s1_zz_reg} + (65'd1 << s1_k_reg);

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_zz_reg   <= s1_zz_reg;
            s2_adj_reg  <= s2_adj_next;
            s2_k_reg    <= s1_k_reg;
            s2_mode_reg <= s1_mode_reg;
        end
    end

    // Stage 3: shift right by k and test for escape
    assign s3_src_next = (s2_mode_reg == gre_pkg::MODE_EXPG) ? s2_adj_reg[63:0] : s2_zz_reg;
    assign s3_sh       = s3_src_next >> s2_k_reg;
    assign s3_esc_next = (s2_mode_reg == gre_pkg::MODE_EXPG)
                         ? (s2_adj_reg[64] || (s3_sh[63:32] != 32'd0))
                         : (s3_sh[63:5] != 59'd0);

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_zz_reg   <= s2_zz_reg;
            s3_src_reg  <= s3_src_next;
            s3_t_reg    <= s3_sh[31:0];
            s3_k_reg    <= s2_k_reg;
            s3_mode_reg <= s2_mode_reg;
            s3_esc_reg  <= s3_esc_next;
        end
    end

    // Stage 4: unary count and payload bit count
    assign s4_pre    = gre_pkg::floor_log2_32(s3_t_reg);
    assign s4_k_wide = {{(gre_pkg::POS_W - KW){1'b0}}, s3_k_reg};

    always_comb
    begin
        if (s3_esc_reg)
        begin
            s4_u_next   = gre_pkg::ESC_UNARY;
            s4_pos_next = gre_pkg::ESC_POS;
            s4_low_next = s3_zz_reg;
        end
        else if (s3_mode_reg == gre_pkg::MODE_EXPG)
        begin
            s4_u_next   = gre_pkg::UNARY_W'(s4_pre);
            s4_pos_next = gre_pkg::POS_W'(s4_pre) + s4_k_wide;
            s4_low_next = s3_src_reg;
        end
        else
        begin
            s4_u_next   = gre_pkg::UNARY_W'(s3_t_reg[4:0]);
            s4_pos_next = s4_k_wide;
            s4_low_next = s3_zz_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_u_reg   <= s4_u_next;
            s4_pos_reg <= s4_pos_next;
            s4_low_reg <= s4_low_next;
            s4_esc_reg <= s3_esc_reg;
        end
    end

    // Stage 5: mask the payload bits, total codeword length
    assign s5_low_next = s4_low_reg & ~(64'hFFFF_FFFF_FFFF_FFFF << s4_pos_reg);
    assign s5_len_next = gre_pkg::POS_W'(s4_u_reg) + s4_pos_reg + 7'd1;

    always_ff @(posedge clk)
    begin
        if (s5_ready)
        begin
            s5_u_reg   <= s4_u_reg;
            s5_pos_reg <= s4_pos_reg;
            s5_low_reg <= s5_low_next;
            s5_len_reg <= s5_len_next;
            s5_esc_reg <= s4_esc_reg;
        end
    end

    // Stage 6: place the unary ones above the stop bit, size the chunks
    assign s6_ones = ~(gre_pkg::ONES32 << s5_u_reg);
    assign s6_lm1  = s5_len_reg - 7'd1;

    always_comb
    begin
        s6_code_next.value   = ({65'd0, s6_ones} << (s5_pos_reg + 7'd1))
                               | {33'd0, s5_low_reg};
        s6_code_next.fin_len = {1'b0, s6_lm1[4:0]} + 6'd1;
        s6_code_next.nlast   = s6_lm1[6:5];
        s6_code_next.esc     = s5_esc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s6_ready)
            s6_code_reg <= s6_code_next;
    end

    // Send the codeword as chunks
    gre_chunker u_chunker (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (s6_valid_reg),
        .code_ready (code_ready),
        .code       (s6_code_reg),
        .chunk      (chunk)
    );

    // A stalled first stage holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_zz_reg))
        else $error("stage 1 word changed under stall");

    // A stalled codeword waits for the chunker unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        s6_valid_reg && !code_ready |=> s6_valid_reg && $stable(s6_code_reg))
        else $error("codeword changed while the chunker was busy");

    // Escape forms carry 32 ones and a 64-bit payload
    assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && s4_esc_reg |-> s4_u_reg == gre_pkg::ESC_UNARY
                                     && s4_pos_reg == gre_pkg::ESC_POS)
        else $error("escape codeword with wrong prefix or payload size");

endmodule

// ===== src/gre_chunker.sv =====
// Output stage: holds one finished codeword and sends it as 32-bit chunks.
// Depends on gre_pkg (code_t, chunk_word_t) and gre_stream_if.
module gre_chunker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              code_valid,
    output logic              code_ready,
    input  gre_pkg::code_t    code,
    gre_stream_if.source      chunk
);

    logic                          hold_valid_reg;
    logic [gre_pkg::CIDX_W-1:0]    cnt_reg;
    logic [gre_pkg::UPPER_W-1:0]   upper_reg;
    logic [gre_pkg::CHUNK_W-1:0]   fin_reg;
    logic [gre_pkg::LEN_W-1:0]     fin_len_reg;
    logic [gre_pkg::CIDX_W-1:0]    nlast_reg;
    logic                          esc_reg;

    logic [gre_pkg::UPPER_W-1:0]   upper_next;
    logic [gre_pkg::CHUNK_W-1:0]   fin_next;
    logic [gre_pkg::CIDX_W-1:0]    sel;
    logic                          is_last;
    logic                          pop;
    logic                          load;

    // Split the codeword: the final chunk is its low bits, the rest are whole words
    assign upper_next = gre_pkg::UPPER_W'(code.value >> code.fin_len);
    assign fin_next   = code.value[gre_pkg::CHUNK_W-1:0]
                        & ~(gre_pkg::ONES32 << code.fin_len);

    assign is_last    = (cnt_reg == nlast_reg);
    assign pop        = hold_valid_reg && chunk.ready;
    assign code_ready = !hold_valid_reg || (chunk.ready && is_last);
    assign load       = code_valid && code_ready;

    // Pick the word for the current chunk, highest word first
    assign sel = nlast_reg - cnt_reg - 2'd1;

    assign chunk.valid           = hold_valid_reg;
    assign chunk.data.chunk_bits = is_last ? fin_reg : upper_reg[{sel, 5'b00000} +: 32];
    assign chunk.data.chunk_len  = is_last ? fin_len_reg : gre_pkg::LEN_W'(gre_pkg::CHUNK_W);
    assign chunk.data.escaped    = esc_reg;
    assign chunk.data.last       = is_last;

    // Track the held codeword and the chunk count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (load)
        begin
            hold_valid_reg <= 1'b1;
            cnt_reg        <= '0;
        end
        else if (pop)
        begin
            if (is_last)
                hold_valid_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    // Capture the codeword payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            upper_reg   <= upper_next;
            fin_reg     <= fin_next;
            fin_len_reg <= code.fin_len;
            nlast_reg   <= code.nlast;
            esc_reg     <= code.esc;
        end
    end

    // Every chunk but the final one is a full word
    assert property (@(posedge clk) disable iff (!rst_n)
        chunk.valid && !chunk.data.last |-> chunk.data.chunk_len == 6'd32)
        else $error("non-final chunk shorter than a full word");

    // An escape codeword ends in a single bit after three full words
    assert property (@(posedge clk) disable iff (!rst_n)
        chunk.valid && chunk.data.escaped |-> nlast_reg == 2'd3 && fin_len_reg == 6'd1)
        else $error("escape codeword with wrong chunk layout");

    // Popping a non-final chunk keeps the codeword and moves to the next chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !is_last |=> hold_valid_reg && cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("codeword lost or chunk repeated after a pop");

endmodule

// ===== verif/gre_chunk_checker.sv =====
// Chunk checker for the Golomb-Rice / Exp-Golomb encoder: watches the three channels,
// predicts every chunk of each accepted residual and compares the output words in order.
// Depends on gre_pkg.
`timescale 1ns / 1ps

module gre_chunk_checker #(
    parameter int MAX_K = gre_pkg::MAX_K_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  gre_pkg::res_word_t   res_data,
    input  logic                 chunk_valid,
    input  logic                 chunk_ready,
    input  gre_pkg::chunk_word_t chunk_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  gre_pkg::cfg_word_t   cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   chunks_seen,
    output int                   escapes_seen
);

    // Shadow copy of the coder registers
    logic [4:0]  rice_k_q;
    logic        coder_q;

    // Chunks still owed by the block, oldest first
    gre_pkg::chunk_word_t pending_chunks[$];

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        $display("%0t: chunk %0d %s: want %0h, got %0h", $time, chunks_seen, field, want, got);
        mismatches++;
    endtask

    // Build the codeword of one residual and split it into chunks
    function automatic void encode_residual(input logic [63:0] r);
        logic [63:0]  zz;
        logic [63:0]  q;
        logic [64:0]  adj;
        logic [127:0] cw;
        int           k;
        int           n;
        int           pre;
        int           len;
        int           pos;
        int           take;
        logic         esc;
        gre_pkg::chunk_word_t w;

        zz  = {r[62:0], 1'b0} ^ {64{r[63]}};
        k   = (rice_k_q > MAX_K) ? MAX_K : int'(rice_k_q);
        esc = 1'b0;
        cw  = '0;
        len = 0;

        if (coder_q == gre_pkg::MODE_RICE)
        begin
            // unary quotient, stop bit, k remainder bits
            q = zz >> k;
            if (q > 64'(gre_pkg::MAX_UNARY))
                esc = 1'b1;
            else
            begin
                cw  = (((128'd1 << q) - 128'd1) << (k + 1))
                    | {64'd0, zz & ((64'd1 << k) - 64'd1)};
                len = int'(q) + 1 + k;
            end
        end
        else
        begin
            // unary of n-k, stop bit, n low bits of zz + 2^k
            adj = {1'b0, zz} + (65'd1 << k);
            if (adj[64])
                esc = 1'b1;
            else
            begin
                n = 0;
                for (int i = 1; i < 64; i++)
                    if (adj[i])
                        n = i;
                pre = n - k;
                if (pre > gre_pkg::MAX_UNARY)
                    esc = 1'b1;
                else
                begin
                    cw  = (((128'd1 << pre) - 128'd1) << (n + 1))
                        | {64'd0, adj[63:0] & ((64'd1 << n) - 64'd1)};
                    len = pre + 1 + n;
                end
            end
        end

        // raw form: 32 ones, a zero, then zz
        if (esc)
        begin
            cw  = {31'd0, gre_pkg::ONES32, 1'b0, zz};
            len = gre_pkg::CODE_W;
        end

        // Cut MSB-first into words of up to 32 bits
        pos = 0;
        while (pos < len)
        begin
            take         = (len - pos > gre_pkg::CHUNK_W) ? gre_pkg::CHUNK_W : len - pos;
            w.chunk_bits = 32'((cw >> (len - pos - take)) & ((128'd1 << take) - 128'd1));
            w.chunk_len  = gre_pkg::LEN_W'(take);
            w.escaped    = esc;
            pos          = pos + take;
            w.last       = (pos >= len);
            pending_chunks.push_back(w);
        end
    endfunction

    // Track registers, predict on each residual, compare each chunk word
    always @(posedge clk or negedge rst_n)
    begin
        gre_pkg::chunk_word_t want;
        if (!rst_n)
        begin
            rice_k_q = '0;
            coder_q  = gre_pkg::MODE_RICE;
            pending_chunks.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data.index == gre_pkg::CFG_RICE_K)
                    rice_k_q = cfg_data.value[4:0];
                else if (cfg_data.index == gre_pkg::CFG_CODER_SELECT)
                    coder_q = cfg_data.value[0];
            end

            if (res_valid && res_ready)
                encode_residual(res_data.residual);

            if (chunk_valid && chunk_ready)
            begin
                if (pending_chunks.size() == 0)
                    report("word with nothing pending", 64'd0, 64'(chunk_data));
                else
                begin
                    want = pending_chunks.pop_front();
                    if (chunk_data.chunk_bits !== want.chunk_bits)
                        report("chunk_bits", 64'(want.chunk_bits), 64'(chunk_data.chunk_bits));
                    if (chunk_data.chunk_len !== want.chunk_len)
                        report("chunk_len", 64'(want.chunk_len), 64'(chunk_data.chunk_len));
                    if (chunk_data.escaped !== want.escaped)
                        report("escaped", 64'(want.escaped), 64'(chunk_data.escaped));
                    if (chunk_data.last !== want.last)
                        report("last", 64'(want.last), 64'(chunk_data.last));
                    if (want.escaped && want.last)
                        escapes_seen++;
                end
                chunks_seen++;
            end

            pending <= pending_chunks.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the encoder testbench: clock, reset, residual and register stimulus, random
// back-pressure, verdict. Depends on gre_pkg, gre_stream_if, the top and the checker.
`timescale 1ns / 1ps

module testbench;

    localparam int               CYCLE_LIMIT   = 200000;
    localparam int               DRAIN_CYCLES  = 20;
    localparam int               PHASE_ITEMS   = 21;
    localparam int               RANDOM_PHASES = 6;
    localparam logic [gre_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'hA5;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   cycle_count;
    int   items_sent;
    int   settings_used;
    int   mismatches;
    int   pending;
    int   chunks_seen;
    int   escapes_seen;

    gre_stream_if #(.word_t(gre_pkg::res_word_t))   res_ch ();
    gre_stream_if #(.word_t(gre_pkg::chunk_word_t)) chunk_ch ();
    gre_stream_if #(.word_t(gre_pkg::cfg_word_t))   cfg_ch ();

    golomb_rice_exp_golomb_encoder #(.MAX_K(gre_pkg::MAX_K_DEFAULT)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res_ch),
        .chunk (chunk_ch),
        .cfg   (cfg_ch)
    );

    gre_chunk_checker #(.MAX_K(gre_pkg::MAX_K_DEFAULT)) checker_u (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_ch.valid),
        .res_ready    (res_ch.ready),
        .res_data     (res_ch.data),
        .chunk_valid  (chunk_ch.valid),
        .chunk_ready  (chunk_ch.ready),
        .chunk_data   (chunk_ch.data),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_data     (cfg_ch.data),
        .mismatches   (mismatches),
        .pending      (pending),
        .chunks_seen  (chunks_seen),
        .escapes_seen (escapes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chunks still pending", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // Log-uniform magnitude with random sign, so short and escaped codes both show up
    function automatic logic signed [63:0] random_residual();
        logic [63:0] mag;
        int          width;
        mag = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0:       width = $urandom_range(1, 8);
            1, 2:    width = $urandom_range(1, 48);
            default: width = 64;
        endcase
        mag = mag >> (64 - width);
        if ($urandom_range(0, 1))
            mag = ~mag;
        return $signed(mag);
    endfunction

    // Hold chunk ready low for a random stall before each word
    initial
    begin
        int stall;
        chunk_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                chunk_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            chunk_ch.ready <= 1'b1;
            @(posedge clk);
            while (!chunk_ch.valid)
                @(posedge clk);
        end
    end

    task automatic send_residual(input logic signed [63:0] r);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            res_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        res_ch.valid         <= 1'b1;
        res_ch.data.residual <= r;
        @(posedge clk);
        while (!res_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted chunk has come out
    task automatic drain();
        res_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [gre_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gre_pkg::CFG_VAL_W-1:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_coder(input logic [gre_pkg::CFG_VAL_W-1:0] k,
                             input logic [gre_pkg::CFG_VAL_W-1:0] sel);
        write_reg(gre_pkg::CFG_RICE_K, k);
        write_reg(gre_pkg::CFG_CODER_SELECT, sel);
        settings_used++;
    endtask

    initial
    begin
        items_sent    = 0;
        settings_used = 1;
        no_idle       = 1'b0;
        res_ch.valid  <= 1'b0;
        res_ch.data   <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        rst_n         <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, Rice with k = 0: unary limit and both extremes
        send_residual(64'sd0);
        send_residual(-64'sd1);
        send_residual(64'sd1);
        send_residual(64'sd15);
        send_residual(-64'sd16);
        send_residual(64'sd16);
        send_residual(64'sh7FFF_FFFF_FFFF_FFFF);
        send_residual(64'sh8000_0000_0000_0000);
        drain();

        // Rice at the largest k: longest plain code, then first escape
        set_coder(32'd16, 32'(gre_pkg::MODE_RICE));
        send_residual(-64'sd1048576);
        send_residual(64'sd1048576);
        send_residual(64'sd0);
        send_residual(64'sd32767);
        drain();

        // Exp-Golomb with k above the clamp; sum overflow and prefix limit
        set_coder(32'd31, 32'(gre_pkg::MODE_EXPG));
        send_residual(64'sd0);
        send_residual(-64'sd1);
        send_residual(64'sh7FFF_FFFF_FFFF_FFFF);
        send_residual(-64'sd140737488322560);
        send_residual(64'sd140737488322560);
        drain();

        // Exp-Golomb order 0
        set_coder(32'd0, 32'(gre_pkg::MODE_EXPG));
        send_residual(64'sd0);
        send_residual(64'sd1);
        send_residual(64'sh8000_0000_0000_0000);
        send_residual(64'sd2147483647);
        send_residual(-64'sd2147483648);
        drain();

        // Random settings, full-width register values, bursts with and without idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_coder($urandom(), $urandom());
            if (p == 2)
                write_reg(CFG_SPARE_IDX, $urandom());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    no_idle = ~no_idle;
                send_residual(random_residual());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d residuals over %0d coder settings; %0d chunks checked, %0d escape codes",
                 items_sent, settings_used, chunks_seen, escapes_seen);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gre_pkg.sv
src/gre_stream_if.sv
src/gre_chunker.sv
src/golomb_rice_exp_golomb_encoder.sv
verif/gre_chunk_checker.sv
verif/testbench.sv
